// ===== src/lbg_pkg.sv =====
// Shared types and constants of the LCD bar graph cell updater.
`default_nettype none
package lbg_pkg;

    localparam int unsigned CELL_BARS  = 5;
    localparam int unsigned MAX_CELLS  = 40;
    localparam logic [14:0] FILL_FULL  = 15'd25600;
    localparam logic [2:0]  GLYPH_FULL  = 3'd5;
    localparam logic [2:0]  GLYPH_BLANK = 3'd0;

    localparam logic [1:0] REG_ROW    = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic [1:0] EMIT_FULL  = 2'd0;
    localparam logic [1:0] EMIT_BLANK = 2'd1;
    localparam logic [1:0] EMIT_PART  = 2'd2;

    typedef struct packed {
        logic [1:0] row;
        logic [5:0] start;
        logic [5:0] len;
    } t_cfg;

    typedef struct packed {
        logic       load_in;
        logic       mul;
        logic       div;
        logic       prep;
        logic       plan;
        logic       emit;
        logic [1:0] emit_kind;
        logic       last;
        logic       step_up;
        logic       step_down;
    } t_cmd;

    typedef struct packed {
        logic in_ok;
        logic grow;
        logic shrink;
        logic full_any;
        logic blank_any;
        logic part;
        logic full_end;
        logic blank_end;
        logic slot_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== src/lbg_cfg.sv =====
// APB configuration registers of the bar graph: row, start column and length.
`default_nettype none
module lbg_cfg
    import lbg_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [1:0] r_row;
    logic [5:0] r_start;
    logic [5:0] r_length;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= 2'd0;
            r_start  <= 6'd0;
            r_length <= 6'd16;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_ROW:    r_row    <= pwdata[1:0];
                REG_START:  r_start  <= pwdata[5:0];
                REG_LENGTH: r_length <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROW:    prdata = {30'd0, r_row};
            REG_START:  prdata = {26'd0, r_start};
            REG_LENGTH: prdata = {26'd0, r_length};
            default:    prdata = 32'd0;
        endcase
    end

    // clamp length to 1..40
    always_comb begin
        o_cfg.row   = r_row;
        o_cfg.start = r_start;
        if (r_length == 6'd0) begin
            o_cfg.len = 6'd1;
        end else if (r_length > 6'(MAX_CELLS)) begin
            o_cfg.len = 6'(MAX_CELLS);
        end else begin
            o_cfg.len = r_length;
        end
    end

endmodule
`default_nettype wire

// ===== src/lbg_ctrl.sv =====
// Controller state machine that sequences target computation and cell writes.
`default_nettype none
module lbg_ctrl
    import lbg_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_PLAN  = 3'd4;
    localparam logic [2:0] S_FULL  = 3'd5;
    localparam logic [2:0] S_BLANK = 3'd6;
    localparam logic [2:0] S_PART  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.in_ok) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                priority if (i_sts.grow && i_sts.full_any) begin
                    n_state = S_FULL;
                end else if (i_sts.shrink && i_sts.blank_any) begin
                    n_state = S_BLANK;
                end else if ((i_sts.grow || i_sts.shrink) && i_sts.part) begin
                    n_state = S_PART;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_FULL;
                    o_cmd.last      = i_sts.full_end && !i_sts.part;
                    if (i_sts.full_end) begin
                        n_state = i_sts.part ? S_PART : S_IDLE;
                    end else begin
                        o_cmd.step_up = 1'b1;
                    end
                end
            end
            S_BLANK: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_BLANK;
                    o_cmd.last      = i_sts.blank_end && !i_sts.part;
                    if (i_sts.blank_end) begin
                        n_state = i_sts.part ? S_PART : S_IDLE;
                    end else begin
                        o_cmd.step_down = 1'b1;
                    end
                end
            end
            S_PART: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_PART;
                    o_cmd.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/lbg_dp.sv =====
// Datapath: target bar count, cell cursor, drawn count and output word register.
`default_nettype none
module lbg_dp
    import lbg_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  t_cfg               i_cfg,
    input  wire signed  [15:0] i_fill_percent,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic        [1:0]  o_cell_row,
    output logic        [6:0]  o_cell_column,
    output logic        [2:0]  o_glyph_code,
    output logic               o_last_write
);

    function automatic logic [7:0] div100(input logic [14:0] y);
        logic [26:0] p;
        p = 27'(y) * 27'd5243;
        return p[26:19];
    endfunction

    function automatic logic [5:0] div5(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return p[15:10];
    endfunction

    logic [14:0] r_raw;
    logic [5:0]  r_len;
    logic [22:0] r_prod;
    logic [7:0]  r_target;
    logic [7:0]  r_drawn;
    logic [5:0]  r_tcell;
    logic [5:0]  r_dcell;
    logic [2:0]  r_tmod;
    logic        r_grow;
    logic        r_shrink;
    logic [5:0]  r_cur;
    logic        r_out_valid;
    logic [1:0]  r_row;
    logic [6:0]  r_col;
    logic [2:0]  r_glyph;
    logic        r_last;

    logic [7:0]  total;
    logic [5:0]  gend;
    logic [5:0]  hi;
    logic [7:0]  tcell5;
    logic [5:0]  emit_cell;
    logic [2:0]  emit_glyph;

    assign total  = (8'(r_len) << 2) + 8'(r_len);
    assign gend   = (r_tcell < r_len) ? r_tcell : r_len;
    assign hi     = (r_dcell < r_len) ? r_dcell : 6'(r_len - 6'd1);
    assign tcell5 = 8'(r_tcell) * 8'd5;

    always_comb begin
        unique case (i_cmd.emit_kind)
            EMIT_FULL: begin
                emit_cell  = r_cur;
                emit_glyph = GLYPH_FULL;
            end
            EMIT_BLANK: begin
                emit_cell  = r_cur;
                emit_glyph = GLYPH_BLANK;
            end
            default: begin
                emit_cell  = r_tcell;
                emit_glyph = r_tmod;
            end
        endcase
    end

    assign o_sts.in_ok     = !i_fill_percent[15] && (i_fill_percent[14:0] <= FILL_FULL);
    assign o_sts.grow      = r_grow;
    assign o_sts.shrink    = r_shrink;
    assign o_sts.full_any  = r_dcell < gend;
    assign o_sts.blank_any = hi >= r_tcell;
    assign o_sts.part      = r_tcell < r_len;
    assign o_sts.full_end  = r_cur == 6'(gend - 6'd1);
    assign o_sts.blank_end = r_cur == r_tcell;
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawn     <= 8'd0;
            r_out_valid <= 1'b0;
            r_grow      <= 1'b0;
            r_shrink    <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_drawn  <= r_target;
                r_grow   <= r_target > r_drawn;
                r_shrink <= r_target < r_drawn;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw <= i_fill_percent[14:0];
            r_len <= i_cfg.len;
        end
        if (i_cmd.mul) begin
            r_prod <= 23'(total) * 23'(r_raw);
        end
        if (i_cmd.div) begin
            r_target <= div100(r_prod[22:8]);
        end
        if (i_cmd.prep) begin
            r_tcell <= div5(r_target);
            r_dcell <= div5(r_drawn);
        end
        if (i_cmd.plan) begin
            r_tmod <= 3'(r_target - tcell5);
            r_cur  <= r_grow ? r_dcell : hi;
        end else if (i_cmd.step_up) begin
            r_cur <= r_cur + 6'd1;
        end else if (i_cmd.step_down) begin
            r_cur <= r_cur - 6'd1;
        end
        if (i_cmd.emit) begin
            r_row   <= i_cfg.row;
            r_col   <= 7'(i_cfg.start) + 7'(emit_cell);
            r_glyph <= emit_glyph;
            r_last  <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_row    = r_row;
    assign o_cell_column = r_col;
    assign o_glyph_code  = r_glyph;
    assign o_last_write  = r_last;

    a_emit_in_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (emit_cell < r_len))
        else $error("cell write past the end of the bar");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    a_glyph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_glyph <= GLYPH_FULL))
        else $error("glyph code out of range");

    a_drawn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prep |=> (r_tcell <= r_len))
        else $error("target cell beyond bar length");

endmodule
`default_nettype wire

// ===== src/lcd_bar_graph_cell_updater_unit.sv =====
// Top level of the LCD bar graph cell updater: registers, controller and datapath.
//
// Each accepted fill word (signed Q8.8 percent) is turned into the cell writes that
// move the drawn bar to floor(5*length*fill/25600) bars. A word below 0 or above
// 100 percent is dropped with no writes. An in-range word computes the target step
// by step (product, divide by 25600, cell split, plan), then the write sequencer
// issues one cell word per cycle through a single output register while the
// consumer takes each word, with N writes (0 to 41) per item. The next word is
// taken once the last write is queued.
`default_nettype none
module lcd_bar_graph_cell_updater_unit
    import lbg_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire         [3:0]  paddr,
    input  wire         [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire signed  [15:0] i_fill_percent,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic        [1:0]  o_cell_row,
    output logic        [6:0]  o_cell_column,
    output logic        [2:0]  o_glyph_code,
    output logic               o_last_write
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    lbg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lbg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lbg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg          (cfg),
        .i_fill_percent (i_fill_percent),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_cell_row     (o_cell_row),
        .o_cell_column  (o_cell_column),
        .o_glyph_code   (o_glyph_code),
        .o_last_write   (o_last_write)
    );

endmodule
`default_nettype wire
